// ----- hw/rtl/mxt_pkg.sv -----
// Shared types and constants for the maximum XOR pair trie unit.
// Used by mxt_core and max_xor_pair_trie_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mxt_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int MAX_ITEMS_DEF = 1024;

    // Node store: two child pointers per entry, pointer 0 means empty.
    localparam int NODE_DEPTH = 32768;
    localparam int NODE_IDX_W = 15;
    localparam int NODE_W     = 2 * NODE_IDX_W;
    localparam int NODES_W    = 16;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } in_word_t;

    typedef struct packed {
        logic [31:0] max_xor;
        logic        overflow;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_ADDR,
        ST_INS_EVAL,
        ST_INS_FILL,
        ST_Q_START,
        ST_Q_VADDR,
        ST_Q_VLOAD,
        ST_Q_ADDR,
        ST_Q_EVAL,
        ST_Q_CMP,
        ST_EMIT
    } mxt_state_t;

endpackage : mxt_pkg
`default_nettype wire

// ----- hw/rtl/mxt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for the node store and the value buffer.
`timescale 1ns / 1ps
`default_nettype none
module mxt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : mxt_ram
`default_nettype wire

// ----- hw/rtl/mxt_core.sv -----
// Sequencer and shared trie walker: inserts words, then queries every held word.
// Depends on mxt_pkg; drives the node store and value buffer RAM ports.
`timescale 1ns / 1ps
`default_nettype none
module mxt_core
    import mxt_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    localparam int AW    = $clog2(MAX_ITEMS),
    localparam int CNT_W = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire in_word_t              item,
    output logic                       node_we,
    output logic [NODE_IDX_W-1:0]      node_waddr,
    output logic [NODE_W-1:0]          node_wdata,
    output logic [NODE_IDX_W-1:0]      node_raddr,
    input  wire logic [NODE_W-1:0]     node_rdata,
    output logic                       vb_we,
    output logic [AW-1:0]              vb_waddr,
    output logic [WORD_BITS-1:0]       vb_wdata,
    output logic [AW-1:0]              vb_raddr,
    input  wire logic [WORD_BITS-1:0]  vb_rdata,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output out_word_t                  res
);

    localparam int LVL_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(WORD_BITS - 1);

    mxt_state_t state_reg, state_next;

    logic [WORD_BITS-1:0]  word_reg;
    logic                  last_reg;
    logic [NODE_IDX_W-1:0] node_reg;
    logic [LVL_W-1:0]      lvl_reg;
    logic [WORD_BITS-1:0]  acc_reg;
    logic [WORD_BITS-1:0]  best_reg;
    logic [NODE_W-1:0]     root_reg;
    logic [NODES_W-1:0]    nodes_used_reg;
    logic [CNT_W-1:0]      items_held_reg;
    logic [CNT_W-1:0]      qi_reg;
    logic                  dropped_reg;

    logic                  drop;
    logic [NODE_W-1:0]     node_data;
    logic                  bit_cur;
    logic                  bit_below;
    logic [NODE_IDX_W-1:0] child_same;
    logic [NODE_IDX_W-1:0] child_other;
    logic [NODE_IDX_W-1:0] new_ptr;
    logic [NODE_W-1:0]     parent_upd;
    logic [NODE_W-1:0]     fill_data;
    logic [LVL_W-1:0]      lvl_dec;
    logic                  qi_end;

    assign drop = (items_held_reg >= CNT_W'(MAX_ITEMS)) ||
                  (({1'b0, nodes_used_reg} + (NODES_W + 1)'(WORD_BITS)) >
                   (NODES_W + 1)'(NODE_DEPTH));

    // Root lives in flops so a fresh set needs no RAM clear.
    assign node_data   = (node_reg == '0) ? root_reg : node_rdata;
    assign bit_cur     = word_reg[lvl_reg];
    assign lvl_dec     = lvl_reg - 1'b1;
    assign bit_below   = word_reg[lvl_dec];
    assign child_same  = bit_cur ? node_data[NODE_W-1:NODE_IDX_W]
                                 : node_data[NODE_IDX_W-1:0];
    assign child_other = bit_cur ? node_data[NODE_IDX_W-1:0]
                                 : node_data[NODE_W-1:NODE_IDX_W];
    assign new_ptr     = nodes_used_reg[NODE_IDX_W-1:0];
    assign parent_upd  = bit_cur ? {new_ptr, node_data[NODE_IDX_W-1:0]}
                                 : {node_data[NODE_W-1:NODE_IDX_W], new_ptr};
    assign fill_data   = (lvl_reg == '0) ? '0 :
                         (bit_below ? {new_ptr, {NODE_IDX_W{1'b0}}}
                                    : {{NODE_IDX_W{1'b0}}, new_ptr});
    assign qi_end      = ((qi_reg + 1'b1) == items_held_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (!drop)
                    begin
                        state_next = ST_INS_ADDR;
                    end
                    else if (item.last)
                    begin
                        state_next = ST_Q_START;
                    end
                end
            end
            ST_INS_ADDR: state_next = ST_INS_EVAL;
            ST_INS_EVAL:
            begin
                if (child_same == '0)
                begin
                    state_next = ST_INS_FILL;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = last_reg ? ST_Q_START : ST_IDLE;
                end
                else
                begin
                    state_next = ST_INS_ADDR;
                end
            end
            ST_INS_FILL:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = last_reg ? ST_Q_START : ST_IDLE;
                end
            end
            ST_Q_START: state_next = (items_held_reg == '0) ? ST_EMIT : ST_Q_VADDR;
            ST_Q_VADDR: state_next = ST_Q_VLOAD;
            ST_Q_VLOAD: state_next = ST_Q_ADDR;
            ST_Q_ADDR:  state_next = ST_Q_EVAL;
            ST_Q_EVAL:  state_next = (lvl_reg == '0) ? ST_Q_CMP : ST_Q_ADDR;
            ST_Q_CMP:   state_next = qi_end ? ST_EMIT : ST_Q_VADDR;
            ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        item_ready = (state_reg == ST_IDLE);
        res_valid  = (state_reg == ST_EMIT);
        node_we    = 1'b0;
        node_waddr = node_reg;
        node_wdata = parent_upd;
        node_raddr = node_reg;
        vb_we      = (state_reg == ST_IDLE) && item_valid && !drop;
        vb_waddr   = items_held_reg[AW-1:0];
        vb_wdata   = item.value[WORD_BITS-1:0];
        vb_raddr   = qi_reg[AW-1:0];
        unique case (state_reg)
            ST_INS_EVAL:
            begin
                node_we = (child_same == '0) && (node_reg != '0);
            end
            ST_INS_FILL:
            begin
                node_we    = 1'b1;
                node_wdata = fill_data;
            end
            default:
            begin
                node_we = 1'b0;
            end
        endcase
    end

    assign res.max_xor  = 32'(best_reg);
    assign res.overflow = dropped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            root_reg       <= '0;
            nodes_used_reg <= NODES_W'(1);
            items_held_reg <= '0;
            best_reg       <= '0;
            dropped_reg    <= 1'b0;
            qi_reg         <= '0;
            word_reg       <= '0;
            last_reg       <= 1'b0;
            node_reg       <= '0;
            lvl_reg        <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        word_reg <= item.value[WORD_BITS-1:0];
                        last_reg <= item.last;
                        node_reg <= '0;
                        lvl_reg  <= LVL_TOP;
                        if (drop)
                        begin
                            dropped_reg <= 1'b1;
                        end
                        else
                        begin
                            items_held_reg <= items_held_reg + 1'b1;
                        end
                    end
                end
                ST_INS_EVAL:
                begin
                    if (child_same == '0)
                    begin
                        // Hook a fresh node under the parent; keep lvl for the fill.
                        if (node_reg == '0)
                        begin
                            root_reg <= parent_upd;
                        end
                        node_reg       <= new_ptr;
                        nodes_used_reg <= nodes_used_reg + 1'b1;
                    end
                    else
                    begin
                        node_reg <= child_same;
                        lvl_reg  <= lvl_dec;
                    end
                end
                ST_INS_FILL:
                begin
                    if (lvl_reg != '0)
                    begin
                        node_reg       <= new_ptr;
                        nodes_used_reg <= nodes_used_reg + 1'b1;
                        lvl_reg        <= lvl_dec;
                    end
                end
                ST_Q_START:
                begin
                    qi_reg <= '0;
                end
                ST_Q_VLOAD:
                begin
                    word_reg <= vb_rdata;
                    node_reg <= '0;
                    lvl_reg  <= LVL_TOP;
                    acc_reg  <= '0;
                end
                ST_Q_EVAL:
                begin
                    if (child_other != '0)
                    begin
                        acc_reg[lvl_reg] <= 1'b1;
                        node_reg         <= child_other;
                    end
                    else
                    begin
                        node_reg <= child_same;
                    end
                    lvl_reg <= lvl_dec;
                end
                ST_Q_CMP:
                begin
                    if (acc_reg > best_reg)
                    begin
                        best_reg <= acc_reg;
                    end
                    qi_reg <= qi_reg + 1'b1;
                end
                ST_EMIT:
                begin
                    if (res_ready)
                    begin
                        // Start the next set afresh.
                        root_reg       <= '0;
                        nodes_used_reg <= NODES_W'(1);
                        items_held_reg <= '0;
                        best_reg       <= '0;
                        dropped_reg    <= 1'b0;
                    end
                end
                default:
                begin
                    last_reg <= last_reg;
                end
            endcase
        end
    end

endmodule : mxt_core
`default_nettype wire

// ----- hw/rtl/max_xor_pair_trie_unit.sv -----
// Top level of the maximum XOR pair trie unit: RAMs, sequencer and output register.
// Depends on mxt_pkg, mxt_ram and mxt_core.
`timescale 1ns / 1ps
`default_nettype none
// Takes a set of words, one per input word, with last set on the final one, and
// returns one result word per set: the greatest XOR of any two held words and an
// overflow flag. Each accepted word is saved in a value buffer of MAX_ITEMS
// entries and inserted MSB first into a binary trie in a 32768-entry node store.
// Insertion accepts the word, then addresses and evaluates one node per level
// that follows an existing branch; at the level where the path first leaves the
// trie it also hooks a fresh node under the parent, and each level below it is
// filled with one more fresh node. After the last word every held word is read
// back from the value buffer and walks the trie through the same node store,
// addressing and evaluating one node per level, before its XOR is compared with
// the best so far. Words arriving when the buffer is full, or when the node
// store could not hold another full path, are dropped and reported through
// overflow. A set with fewer than two words returns zero. The trie root is kept
// in flops, so no clearing pass is needed after reset or between sets. The
// result sits in an output register, so the next set may start while a result
// still waits to be taken.
module max_xor_pair_trie_unit
    import mxt_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire in_word_t  item,
    output logic           result_valid,
    input  wire logic      result_ready,
    output out_word_t      result
);

    localparam int AW = $clog2(MAX_ITEMS);

    logic                  node_we;
    logic [NODE_IDX_W-1:0] node_waddr;
    logic [NODE_W-1:0]     node_wdata;
    logic [NODE_IDX_W-1:0] node_raddr;
    logic [NODE_W-1:0]     node_rdata;
    logic                  vb_we;
    logic [AW-1:0]         vb_waddr;
    logic [WORD_BITS-1:0]  vb_wdata;
    logic [AW-1:0]         vb_raddr;
    logic [WORD_BITS-1:0]  vb_rdata;
    logic                  res_valid;
    logic                  res_ready;
    out_word_t             res;

    logic                  result_valid_reg;
    out_word_t             result_reg;

    // Node store: child1 in the upper half, child0 in the lower half.
    mxt_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_node_store (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Value buffer: words of the current set, read back for the query pass.
    mxt_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_value_buffer (
        .clk   (clk),
        .we    (vb_we),
        .waddr (vb_waddr),
        .wdata (vb_wdata),
        .raddr (vb_raddr),
        .rdata (vb_rdata)
    );

    mxt_core #(
        .WORD_BITS (WORD_BITS),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .node_we    (node_we),
        .node_waddr (node_waddr),
        .node_wdata (node_wdata),
        .node_raddr (node_raddr),
        .node_rdata (node_rdata),
        .vb_we      (vb_we),
        .vb_waddr   (vb_waddr),
        .vb_wdata   (vb_wdata),
        .vb_raddr   (vb_raddr),
        .vb_rdata   (vb_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Take a new result when the register is empty or is being drained.
    assign res_ready = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Hold the payload until the word is taken.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule : max_xor_pair_trie_unit
`default_nettype wire
